// ----- hdl/wart_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard address rewrite table - shared definitions
// Table geometry, register indexes and the address and rule types.
// ----------------------------------------------------------------------------
package wart_pkg;

	localparam int RULES = 16;
	localparam int RULE_W = (RULES > 1) ? $clog2(RULES) : 1;
	localparam int CNT_W = $clog2(RULES + 1);

	localparam int PART_W = 16;
	localparam int INUSE_W = 5;
	localparam int MRULE_W = 4;
	localparam int SLOT_W = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RULES_IN_USE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WILDCARD = 1'd1;

	// action codes
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_REWRITE = 1'b1;

	typedef struct packed {
		logic [PART_W-1:0] zone;
		logic [PART_W-1:0] net;
		logic [PART_W-1:0] node;
		logic [PART_W-1:0] point;
	} addr_t;

	typedef struct packed {
		addr_t pat;
		addr_t rep;
	} rule_t;

	typedef struct packed {
		logic              hit;
		logic [MRULE_W-1:0] matched_rule;
		addr_t             addr;
	} res_t;

	typedef struct packed {
		logic              we;
		logic [RULE_W-1:0] wr_addr;
		rule_t             wr_data;
		logic              re;
		logic [RULE_W-1:0] rd_addr;
	} mem_req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

// ----- hdl/wart_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard address rewrite table - channel interfaces
// Request channel (rule writes and rewrites) and result channel.
// ----------------------------------------------------------------------------
interface wart_in_if;
	logic                            valid;
	logic                            ready;
	logic                            action;
	logic [wart_pkg::SLOT_W-1:0]     rule_index;
	logic [wart_pkg::PART_W-1:0]     key_zone;
	logic [wart_pkg::PART_W-1:0]     key_net;
	logic [wart_pkg::PART_W-1:0]     key_node;
	logic [wart_pkg::PART_W-1:0]     key_point;
	logic [wart_pkg::PART_W-1:0]     new_zone;
	logic [wart_pkg::PART_W-1:0]     new_net;
	logic [wart_pkg::PART_W-1:0]     new_node;
	logic [wart_pkg::PART_W-1:0]     new_point;

	modport source (
		output valid, action, rule_index, key_zone, key_net, key_node, key_point,
			new_zone, new_net, new_node, new_point,
		input ready
	);
	modport sink (
		input valid, action, rule_index, key_zone, key_net, key_node, key_point,
			new_zone, new_net, new_node, new_point,
		output ready
	);
endinterface

interface wart_out_if;
	logic                         valid;
	logic                         ready;
	logic                         hit;
	logic [wart_pkg::MRULE_W-1:0] matched_rule;
	logic [wart_pkg::PART_W-1:0]  zone;
	logic [wart_pkg::PART_W-1:0]  net;
	logic [wart_pkg::PART_W-1:0]  node;
	logic [wart_pkg::PART_W-1:0]  point;

	modport source (
		output valid, hit, matched_rule, zone, net, node, point,
		input ready
	);
	modport sink (
		input valid, hit, matched_rule, zone, net, node, point,
		output ready
	);
endinterface

// ----- hdl/wart_rule_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard address rewrite table - rule store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wart_rule_mem (
	input  logic               clk,
	input  wart_pkg::mem_req_t mem_req,
	output wart_pkg::rule_t    rd_data_s1
);

	wart_pkg::rule_t rule_mem [wart_pkg::RULES];

	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			rule_mem[mem_req.wr_addr] <= mem_req.wr_data;
		end
		if (mem_req.re) begin
			rd_data_s1 <= rule_mem[mem_req.rd_addr];
		end
	end

endmodule

// ----- hdl/wart_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard address rewrite table - scan controller
// Accepts items, stores rules, walks the table one rule a cycle and holds
// the result in an output register.
// ----------------------------------------------------------------------------
module wart_scan (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [wart_pkg::INUSE_W-1:0]      rules_in_use,
	input  logic [wart_pkg::PART_W-1:0]       wildcard_value,
	wart_in_if.sink                           req,
	wart_out_if.source                        rsp,
	output wart_pkg::mem_req_t                mem_req,
	input  wart_pkg::rule_t                   rd_data_s1
);

	wart_pkg::state_t state_q, state_d;

	wart_pkg::addr_t                addr_q;
	logic [wart_pkg::CNT_W-1:0]     limit_q;
	logic [wart_pkg::CNT_W-1:0]     limit_in;
	logic [wart_pkg::CNT_W-1:0]     ptr_q;
	logic                           vld_s1;
	logic [wart_pkg::RULE_W-1:0]    idx_s1;
	wart_pkg::res_t                 res_q;
	wart_pkg::res_t                 out_q;
	logic                           out_vld_q;

	wart_pkg::addr_t                key;
	wart_pkg::addr_t                rew_addr;
	logic                           accept;
	logic                           is_write;
	logic                           slot_ok;
	logic                           match;
	logic                           last;
	logic                           finish;
	logic                           load_out;
	logic                           rd_en;

	assign key = '{zone: req.key_zone, net: req.key_net, node: req.key_node,
		point: req.key_point};
	assign is_write = (req.action == wart_pkg::ACT_WRITE);
	assign slot_ok = (32'(req.rule_index) < wart_pkg::RULES);
	assign limit_in = (32'(rules_in_use) > wart_pkg::RULES) ?
		wart_pkg::CNT_W'(wart_pkg::RULES) : wart_pkg::CNT_W'(rules_in_use);

	// pattern part matches on wildcard or equality; wildcard replacement keeps part
	always_comb begin
		match = (rd_data_s1.pat.zone == wildcard_value || rd_data_s1.pat.zone == addr_q.zone)
			&& (rd_data_s1.pat.net == wildcard_value || rd_data_s1.pat.net == addr_q.net)
			&& (rd_data_s1.pat.node == wildcard_value || rd_data_s1.pat.node == addr_q.node)
			&& (rd_data_s1.pat.point == wildcard_value
				|| rd_data_s1.pat.point == addr_q.point);
		rew_addr.zone = (rd_data_s1.rep.zone == wildcard_value) ? addr_q.zone
			: rd_data_s1.rep.zone;
		rew_addr.net = (rd_data_s1.rep.net == wildcard_value) ? addr_q.net
			: rd_data_s1.rep.net;
		rew_addr.node = (rd_data_s1.rep.node == wildcard_value) ? addr_q.node
			: rd_data_s1.rep.node;
		rew_addr.point = (rd_data_s1.rep.point == wildcard_value) ? addr_q.point
			: rd_data_s1.rep.point;
	end

	assign last = (wart_pkg::CNT_W'(idx_s1) == limit_q - wart_pkg::CNT_W'(1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			wart_pkg::ST_IDLE: begin
				if (req.valid) begin
					if (is_write || limit_in == '0) begin
						state_d = wart_pkg::ST_DONE;
					end else begin
						state_d = wart_pkg::ST_SCAN;
					end
				end
			end
			wart_pkg::ST_SCAN: begin
				if (vld_s1 && (match || last)) begin
					state_d = wart_pkg::ST_DONE;
				end
			end
			wart_pkg::ST_DONE: begin
				if (!out_vld_q || rsp.ready) begin
					state_d = wart_pkg::ST_IDLE;
				end
			end
			default: state_d = wart_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req.ready = 1'b0;
		rd_en = 1'b0;
		finish = 1'b0;
		load_out = 1'b0;
		case (state_q)
			wart_pkg::ST_IDLE: begin
				req.ready = 1'b1;
			end
			wart_pkg::ST_SCAN: begin
				rd_en = (ptr_q < limit_q);
				finish = vld_s1 && (match || last);
			end
			wart_pkg::ST_DONE: begin
				load_out = !out_vld_q || rsp.ready;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	assign accept = req.valid && req.ready;

	always_comb begin
		mem_req.we = accept && is_write && slot_ok;
		mem_req.wr_addr = wart_pkg::RULE_W'(req.rule_index);
		mem_req.wr_data.pat = key;
		mem_req.wr_data.rep = '{zone: req.new_zone, net: req.new_net,
			node: req.new_node, point: req.new_point};
		mem_req.re = rd_en;
		mem_req.rd_addr = ptr_q[wart_pkg::RULE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wart_pkg::ST_IDLE;
			vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1 <= rd_en && !finish;
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= key;
			limit_q <= limit_in;
			ptr_q <= '0;
			res_q.hit <= 1'b0;
			res_q.matched_rule <= '0;
			res_q.addr <= is_write ? '0 : key;
		end else if (rd_en) begin
			ptr_q <= ptr_q + wart_pkg::CNT_W'(1);
		end
		idx_s1 <= ptr_q[wart_pkg::RULE_W-1:0];
		if (finish) begin
			res_q.hit <= match;
			res_q.matched_rule <= match ? wart_pkg::MRULE_W'(idx_s1) : '0;
			res_q.addr <= match ? rew_addr : addr_q;
		end
		if (load_out) begin
			out_q <= res_q;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.hit = out_q.hit;
	assign rsp.matched_rule = out_q.matched_rule;
	assign rsp.zone = out_q.addr.zone;
	assign rsp.net = out_q.addr.net;
	assign rsp.node = out_q.addr.node;
	assign rsp.point = out_q.addr.point;

`ifndef NO_ASSERTIONS
	// a compare stage only follows a read issued while scanning
	a_s1_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $past(state_q == wart_pkg::ST_SCAN))
		else $error("compare stage valid outside a scan");

	// a hit never names a rule beyond the scan limit
	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && match) |-> (wart_pkg::CNT_W'(idx_s1) < limit_q))
		else $error("hit on rule beyond scan limit");

	// a rule write completes without a scan
	a_write_no_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_write) |=> (state_q == wart_pkg::ST_DONE))
		else $error("rule write entered a scan");

	// no table read outside a scan
	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.re |-> (state_q == wart_pkg::ST_SCAN && !accept))
		else $error("table read outside a scan");
`endif

endmodule

// ----- hdl/wildcard_address_rewrite_table.sv -----
`timescale 1ns / 1ps
// Results: a write or an empty scan is passed straight to the done state; a rewrite
// stops at the first matching rule k (a miss stops at the last rule). The result is
// then loaded into the output register once it is free. One item at a time; a rewrite
// reads up to min(rules_in_use, RULES) rules, the single table read port giving one rule a cycle.
// Reset clears control state and registers (rules_in_use 0, wildcard 0xFFFF);
// the rule table is not cleared and holds nothing defined until written.
// ----------------------------------------------------------------------------
// Wildcard address rewrite table - top level
// Configuration registers, rule store and scan controller.
// ----------------------------------------------------------------------------
module wildcard_address_rewrite_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [wart_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wart_pkg::CFG_DATA_W-1:0]   cfg_data,
	wart_in_if.sink                           req,
	wart_out_if.source                        rsp
);

	logic [wart_pkg::INUSE_W-1:0] rules_in_use_q;
	logic [wart_pkg::PART_W-1:0]  wildcard_q;
	wart_pkg::mem_req_t           mem_req;
	wart_pkg::rule_t              rd_data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rules_in_use_q <= '0;
			wildcard_q <= '1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				wart_pkg::REG_RULES_IN_USE: rules_in_use_q <= cfg_data[wart_pkg::INUSE_W-1:0];
				wart_pkg::REG_WILDCARD: wildcard_q <= cfg_data[wart_pkg::PART_W-1:0];
				default: ;
			endcase
		end
	end

	wart_rule_mem u_rule_mem (
		.clk        (clk),
		.mem_req    (mem_req),
		.rd_data_s1 (rd_data_s1)
	);

	wart_scan u_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.rules_in_use   (rules_in_use_q),
		.wildcard_value (wildcard_q),
		.req            (req),
		.rsp            (rsp),
		.mem_req        (mem_req),
		.rd_data_s1     (rd_data_s1)
	);

endmodule
